FILE: hw/rtl/ipc_pkg.sv
// Package for the incremental PI controller: register indices, mode codes and
// the configuration struct shared by the register block, the update logic and the top level.
// No dependencies.
`default_nettype none

package ipc_pkg;

   localparam int GAIN_W      = 24;
   localparam int LIMIT_W     = 31;
   localparam int DRIVE_W     = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 31;

   localparam logic [CSR_INDEX_W-1:0] REG_MODE   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_IGAIN  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_PGAIN  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_LIMIT  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_DECAY  = 3'd4;

   localparam logic [1:0] MODE_WIND = 2'd0;
   localparam logic [1:0] MODE_RUN  = 2'd1;
   localparam logic [1:0] MODE_HOLD = 2'd2;

   typedef struct packed {
      logic [1:0]         mode;
      logic [GAIN_W-1:0]  integral_gain;
      logic [GAIN_W-1:0]  proportional_gain;
      logic [LIMIT_W-1:0] drive_limit;
      logic [LIMIT_W-1:0] decay_step;
   } cfg_type;

endpackage

`default_nettype wire

FILE: hw/rtl/ipc_csr.sv
// Configuration registers of the incremental PI controller.
// Depends on ipc_pkg.
`default_nettype none

module ipc_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_write,
   input  wire logic [ipc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [ipc_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output ipc_pkg::cfg_type                        cfg
);
   import ipc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            REG_MODE:  cfg_in.mode              = csr_wdata[1:0];
            REG_IGAIN: cfg_in.integral_gain     = csr_wdata[GAIN_W-1:0];
            REG_PGAIN: cfg_in.proportional_gain = csr_wdata[GAIN_W-1:0];
            REG_LIMIT: cfg_in.drive_limit       = csr_wdata[LIMIT_W-1:0];
            REG_DECAY: cfg_in.decay_step        = csr_wdata[LIMIT_W-1:0];
            default:   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode              <= MODE_WIND;
         cfg_ff.integral_gain     <= '0;
         cfg_ff.proportional_gain <= '0;
         cfg_ff.drive_limit       <= '1;
         cfg_ff.decay_step        <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/ipc_update.sv
// Drive update for one tick: PI increment with rounding and clamp, wind-down
// toward zero, or hold. Depends on ipc_pkg.
`default_nettype none

module ipc_update #(
   parameter int SAMPLE_WIDTH   = 16,
   parameter int GAIN_FRAC_BITS = 16
) (
   input  ipc_pkg::cfg_type                       cfg,
   input  wire logic signed [SAMPLE_WIDTH-1:0]    setpoint,
   input  wire logic signed [SAMPLE_WIDTH-1:0]    measured,
   input  wire logic signed [SAMPLE_WIDTH-1:0]    last_measured,
   input  wire logic signed [ipc_pkg::DRIVE_W-1:0] drive_now,
   output logic signed [ipc_pkg::DRIVE_W-1:0]     drive_next
);
   import ipc_pkg::*;

   localparam int ERR_W  = SAMPLE_WIDTH + 1;
   localparam int PROD_W = ERR_W + GAIN_W + 1;
   localparam int ACC_W  = PROD_W + 1;
   localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (GAIN_FRAC_BITS - 1);

   logic signed [ERR_W-1:0]   err;
   logic signed [ERR_W-1:0]   chg;
   logic signed [GAIN_W:0]    gain_i;
   logic signed [GAIN_W:0]    gain_p;
   logic signed [PROD_W-1:0]  prod_i;
   logic signed [PROD_W-1:0]  prod_p;
   logic signed [ACC_W-1:0]   acc;
   logic signed [ACC_W-1:0]   inc;
   logic signed [ACC_W-1:0]   sum;
   logic signed [ACC_W-1:0]   lim;
   logic signed [DRIVE_W-1:0] run_drive;
   logic signed [DRIVE_W:0]   d_x;
   logic signed [DRIVE_W:0]   st_x;
   logic signed [DRIVE_W:0]   wind_x;

   assign err    = ERR_W'(setpoint) - ERR_W'(measured);
   assign chg    = ERR_W'(measured) - ERR_W'(last_measured);
   assign gain_i = {1'b0, cfg.integral_gain};
   assign gain_p = {1'b0, cfg.proportional_gain};
   assign prod_i = PROD_W'(err) * PROD_W'(gain_i);
   assign prod_p = PROD_W'(chg) * PROD_W'(gain_p);

   always_comb begin
      acc = ACC_W'(prod_i) - ACC_W'(prod_p) + HALF;
      inc = acc >>> GAIN_FRAC_BITS;
      sum = ACC_W'(drive_now) + inc;
      lim = ACC_W'({1'b0, cfg.drive_limit});
      if (sum > lim) begin
         run_drive = lim[DRIVE_W-1:0];
      end else if (sum < -lim) begin
         run_drive = DRIVE_W'(-lim);
      end else begin
         run_drive = sum[DRIVE_W-1:0];
      end
   end

   always_comb begin
      d_x  = (DRIVE_W+1)'(drive_now);
      st_x = {2'b00, cfg.decay_step};
      if (d_x > st_x) begin
         wind_x = d_x - st_x;
      end else if (d_x < -st_x) begin
         wind_x = d_x + st_x;
      end else begin
         wind_x = '0;
      end
   end

   always_comb begin
      case (cfg.mode)
         MODE_RUN:  drive_next = run_drive;
         MODE_WIND: drive_next = wind_x[DRIVE_W-1:0];
         default:   drive_next = drive_now;
      endcase
   end

endmodule

`default_nettype wire

FILE: hw/rtl/incremental_pi_controller_top.sv
// Incremental PI controller: input register, one-pass drive update, result register.
// An accepted beat waits in the input register until the result register is free, then its result is registered there.
// Throughput: one beat per cycle while the receiver takes results; the drive and last
// measurement feed back through the combinational update logic.
// Reset (synchronous): registers to defaults, drive and last measurement to zero.
// Depends on ipc_pkg, ipc_csr and ipc_update.
`default_nettype none

module incremental_pi_controller_top #(
   parameter int SAMPLE_WIDTH   = 16,
   parameter int GAIN_FRAC_BITS = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic signed [SAMPLE_WIDTH-1:0]       req_setpoint,
   input  wire logic signed [SAMPLE_WIDTH-1:0]       req_measured,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic signed [ipc_pkg::DRIVE_W-1:0]        rsp_drive,
   input  wire logic                                 csr_write,
   input  wire logic [ipc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [ipc_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import ipc_pkg::*;

   cfg_type cfg;

   logic                            in_valid_ff;
   logic signed [SAMPLE_WIDTH-1:0]  setpoint_ff;
   logic signed [SAMPLE_WIDTH-1:0]  measured_ff;
   logic signed [SAMPLE_WIDTH-1:0]  last_meas_ff;
   logic signed [DRIVE_W-1:0]       drive_ff;
   logic signed [DRIVE_W-1:0]       drive_in;
   logic                            rsp_valid_ff;
   logic signed [DRIVE_W-1:0]       rsp_drive_ff;
   logic                            advance;

   ipc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ipc_update #(
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_update (
      .cfg           (cfg),
      .setpoint      (setpoint_ff),
      .measured      (measured_ff),
      .last_measured (last_meas_ff),
      .drive_now     (drive_ff),
      .drive_next    (drive_in)
   );

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         last_meas_ff <= '0;
         drive_ff     <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            last_meas_ff <= measured_ff;
            drive_ff     <= drive_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         setpoint_ff <= req_setpoint;
         measured_ff <= req_measured;
      end
      if (advance) begin
         rsp_drive_ff <= drive_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = rsp_drive_ff;

`ifndef SYNTHESIS
   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(measured_ff) && $stable(setpoint_ff))
      else $error("stalled input beat lost or changed");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_ready)
      else $error("empty input stage not ready");

   a_result_state: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid && rsp_drive == drive_ff)
      else $error("result beat differs from stored drive");

   a_last_meas: assert property (@(posedge clock) disable iff (reset)
      advance |=> last_meas_ff == $past(measured_ff))
      else $error("last measurement not advanced");
`endif

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking bench for incremental_pi_controller_top: directed table, then randomised
// register settings and control ticks checked beat by beat against an in-bench drive predictor.
// Depends on ipc_pkg and the controller RTL.
`timescale 1ns / 1ps

module tb;
   import ipc_pkg::*;

   localparam int SAMPLE_W = 16;
   localparam int FRAC_W   = 16;
   localparam int PHASES   = 12;
   localparam int PHASE_TICKS = 140;
   localparam longint ROUND_HALF = 64'sd1 <<< (FRAC_W - 1);
   localparam logic [1:0] MODE_SPARE = 2'd3;
   localparam logic [GAIN_W-1:0]  GAIN_MAX  = '1;
   localparam logic [LIMIT_W-1:0] LIMIT_MAX = '1;
   localparam logic [CSR_DATA_W-1:0] DATA_ALL = '1;

   typedef enum logic {ROW_WRITE, ROW_TICK} row_kind_type;

   typedef struct {
      row_kind_type                 kind;
      logic [CSR_INDEX_W-1:0]       index;
      logic [CSR_DATA_W-1:0]        data;
      logic signed [SAMPLE_W-1:0]   setpoint;
      logic signed [SAMPLE_W-1:0]   measured;
      logic                         has_drive;
      logic signed [DRIVE_W-1:0]    drive;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [SAMPLE_W-1:0] req_setpoint = '0;
   logic signed [SAMPLE_W-1:0] req_measured = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [DRIVE_W-1:0] rsp_drive;
   logic csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // predictor state
   cfg_type ctl_cfg;
   logic signed [SAMPLE_W-1:0] meas_prev;
   logic signed [DRIVE_W-1:0]  drive_now;
   logic signed [DRIVE_W-1:0]  drive_expected[$];

   logic tick_has_drive = 1'b0;
   logic signed [DRIVE_W-1:0] tick_drive = '0;

   int mismatch_count = 0;
   int beats_checked = 0;
   int ticks_taken = 0;
   int writes_done = 0;
   int run_ticks = 0;
   int wind_ticks = 0;
   int hold_ticks = 0;

   int stall_left = 0;
   int stall_style = 0;

   plan_row_type directed_plan[$];

   incremental_pi_controller_top #(
      .SAMPLE_WIDTH   (SAMPLE_W),
      .GAIN_FRAC_BITS (FRAC_W)
   ) i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_setpoint (req_setpoint),
      .req_measured (req_measured),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_drive    (rsp_drive),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #5ns clock = ~clock;

   function automatic logic signed [DRIVE_W-1:0] next_drive(
      input logic signed [SAMPLE_W-1:0] sp,
      input logic signed [SAMPLE_W-1:0] ms
   );
      longint err;
      longint chg;
      longint acc;
      longint lim;
      longint st;
      longint nxt;
      nxt = longint'(drive_now);
      if (ctl_cfg.mode == MODE_RUN) begin
         err = longint'(sp) - longint'(ms);
         chg = longint'(ms) - longint'(meas_prev);
         acc = err * longint'(ctl_cfg.integral_gain)
             - chg * longint'(ctl_cfg.proportional_gain);
         nxt = nxt + ((acc + ROUND_HALF) >>> FRAC_W);
         lim = longint'(ctl_cfg.drive_limit);
         if (nxt > lim) nxt = lim;
         if (nxt < -lim) nxt = -lim;
      end else if (ctl_cfg.mode == MODE_WIND) begin
         st = longint'(ctl_cfg.decay_step);
         if (nxt > st) nxt = nxt - st;
         else if (nxt < -st) nxt = nxt + st;
         else nxt = 0;
      end
      return nxt[DRIVE_W-1:0];
   endfunction

   function automatic plan_row_type csr_row(input logic [CSR_INDEX_W-1:0] idx,
                                            input logic [CSR_DATA_W-1:0] data);
      plan_row_type r;
      r = '{ROW_WRITE, idx, data, '0, '0, 1'b0, '0};
      return r;
   endfunction

   function automatic plan_row_type tick_row(input int sp, input int ms,
                                             input logic has, input int drv);
      plan_row_type r;
      r = '{ROW_TICK, '0, '0, SAMPLE_W'(sp), SAMPLE_W'(ms), has, DRIVE_W'(drv)};
      return r;
   endfunction

   function automatic logic [GAIN_W-1:0] pick_gain();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return GAIN_MAX;
         2: return GAIN_W'($urandom);
         default: return GAIN_W'($urandom_range(0, 32'h20000));
      endcase
   endfunction

   // predict on accepted request beats, compare accepted drive beats
   always @(posedge clock) begin
      logic signed [DRIVE_W-1:0] nxt;
      logic signed [DRIVE_W-1:0] want;
      if (reset) begin
         ctl_cfg.mode              = MODE_WIND;
         ctl_cfg.integral_gain     = '0;
         ctl_cfg.proportional_gain = '0;
         ctl_cfg.drive_limit       = LIMIT_MAX;
         ctl_cfg.decay_step        = '0;
         meas_prev = '0;
         drive_now = '0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               REG_MODE:  ctl_cfg.mode              = csr_wdata[1:0];
               REG_IGAIN: ctl_cfg.integral_gain     = csr_wdata[GAIN_W-1:0];
               REG_PGAIN: ctl_cfg.proportional_gain = csr_wdata[GAIN_W-1:0];
               REG_LIMIT: ctl_cfg.drive_limit       = csr_wdata[LIMIT_W-1:0];
               REG_DECAY: ctl_cfg.decay_step        = csr_wdata[LIMIT_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            nxt = next_drive(req_setpoint, req_measured);
            drive_expected.push_back(tick_has_drive ? tick_drive : nxt);
            if (ctl_cfg.mode == MODE_RUN) run_ticks++;
            else if (ctl_cfg.mode == MODE_WIND) wind_ticks++;
            else hold_ticks++;
            drive_now = nxt;
            meas_prev = req_measured;
            ticks_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            if (drive_expected.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 20)
                  $display("%0t: drive beat with nothing expected, actual %0d",
                           $realtime, rsp_drive);
            end else begin
               want = drive_expected.pop_front();
               beats_checked++;
               if (rsp_drive !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 20)
                     $display("%0t: drive mismatch, expected %0d, actual %0d",
                              $realtime, want, rsp_drive);
               end
            end
         end
      end
   end

   // receiver stall pattern
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_style = $urandom_range(0, 3);
         stall_left  = (stall_style == 3) ? $urandom_range(1, 8) : $urandom_range(16, 200);
      end
      stall_left--;
      case (stall_style)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 1) == 0);
         2: rsp_ready <= ($urandom_range(0, 4) == 0);
         default: rsp_ready <= 1'b0;
      endcase
   end

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_write = 1'b0;
      writes_done++;
   endtask

   task automatic send_tick(input logic signed [SAMPLE_W-1:0] sp,
                            input logic signed [SAMPLE_W-1:0] ms,
                            input logic has, input logic signed [DRIVE_W-1:0] drv);
      req_setpoint   = sp;
      req_measured   = ms;
      tick_has_drive = has;
      tick_drive     = drv;
      req_valid      = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (drive_expected.size() != 0) @(negedge clock);
   endtask

   task automatic pause(input int cycles);
      req_valid = 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   initial begin
      plan_row_type row;
      int sp_base;
      int ms_walk;
      int left;
      int burst;
      int pick;
      logic [1:0] mode_code;
      logic signed [SAMPLE_W-1:0] sp;
      logic signed [SAMPLE_W-1:0] ms;

      directed_plan.push_back(tick_row(0, 0, 1'b1, 0));
      directed_plan.push_back(tick_row(32767, -32768, 1'b1, 0));
      directed_plan.push_back(csr_row(REG_MODE, 31'h7FFF_FFFD));
      directed_plan.push_back(csr_row(REG_IGAIN, DATA_ALL));
      directed_plan.push_back(csr_row(REG_PGAIN, DATA_ALL));
      directed_plan.push_back(csr_row(REG_LIMIT, 31'd1000));
      directed_plan.push_back(tick_row(32767, -32768, 1'b1, 1000));
      directed_plan.push_back(tick_row(-32768, 32767, 1'b1, -1000));
      directed_plan.push_back(tick_row(32767, -32768, 1'b1, 1000));
      directed_plan.push_back(csr_row(REG_LIMIT, '0));
      directed_plan.push_back(tick_row(100, -5, 1'b1, 0));
      directed_plan.push_back(csr_row(REG_LIMIT, DATA_ALL));
      directed_plan.push_back(tick_row(32767, -32768, 1'b0, 0));
      directed_plan.push_back(tick_row(-32768, 32767, 1'b0, 0));
      directed_plan.push_back(tick_row(0, 0, 1'b0, 0));
      directed_plan.push_back(csr_row(REG_IGAIN, 31'h8000));
      directed_plan.push_back(csr_row(REG_PGAIN, '0));
      directed_plan.push_back(tick_row(1, 0, 1'b0, 0));
      directed_plan.push_back(tick_row(-1, 0, 1'b0, 0));
      directed_plan.push_back(tick_row(0, 0, 1'b0, 0));
      directed_plan.push_back(csr_row(REG_MODE, 31'(MODE_SPARE)));
      directed_plan.push_back(tick_row(5000, -7, 1'b0, 0));
      directed_plan.push_back(csr_row(REG_MODE, 31'(MODE_WIND)));
      directed_plan.push_back(csr_row(REG_DECAY, DATA_ALL));
      directed_plan.push_back(tick_row(-32768, 32767, 1'b1, 0));
      directed_plan.push_back(csr_row(REG_MODE, 31'(MODE_RUN)));
      directed_plan.push_back(csr_row(REG_IGAIN, 31'(GAIN_MAX)));
      directed_plan.push_back(csr_row(REG_LIMIT, 31'd1000000));
      directed_plan.push_back(tick_row(32767, -32768, 1'b1, 1000000));
      directed_plan.push_back(csr_row(REG_LIMIT, 31'd10));
      directed_plan.push_back(csr_row(REG_MODE, 31'(MODE_HOLD)));
      directed_plan.push_back(tick_row(0, 0, 1'b1, 1000000));
      directed_plan.push_back(csr_row(REG_MODE, 31'(MODE_RUN)));
      directed_plan.push_back(csr_row(REG_IGAIN, '0));
      directed_plan.push_back(tick_row(123, -456, 1'b1, 10));
      directed_plan.push_back(csr_row(REG_LIMIT, DATA_ALL));
      directed_plan.push_back(csr_row(REG_IGAIN, 31'h10000));
      directed_plan.push_back(tick_row(1000, 0, 1'b0, 0));
      directed_plan.push_back(csr_row(REG_MODE, 31'(MODE_WIND)));
      directed_plan.push_back(csr_row(REG_DECAY, 31'd300));
      directed_plan.push_back(tick_row(7, 7, 1'b0, 0));
      directed_plan.push_back(tick_row(-7, 9, 1'b0, 0));
      directed_plan.push_back(tick_row(0, 0, 1'b0, 0));
      directed_plan.push_back(tick_row(0, 0, 1'b0, 0));
      directed_plan.push_back(csr_row(REG_MODE, 31'(MODE_RUN)));
      directed_plan.push_back(tick_row(-3000, 0, 1'b0, 0));
      directed_plan.push_back(csr_row(REG_MODE, 31'(MODE_WIND)));
      directed_plan.push_back(tick_row(0, 0, 1'b0, 0));
      directed_plan.push_back(csr_row(REG_DECAY + 3'd1, DATA_ALL));
      directed_plan.push_back(csr_row(REG_DECAY + 3'd2, DATA_ALL));
      directed_plan.push_back(csr_row(REG_DECAY + 3'd3, '0));
      directed_plan.push_back(tick_row(0, 0, 1'b0, 0));

      repeat (10) @(negedge clock);
      reset = 1'b0;

      foreach (directed_plan[i]) begin
         row = directed_plan[i];
         if (row.kind == ROW_WRITE) begin
            drain();
            write_reg(row.index, row.data);
         end else begin
            send_tick(row.setpoint, row.measured, row.has_drive, row.drive);
         end
      end

      ms_walk = 0;
      for (int p = 0; p < PHASES; p++) begin
         drain();
         pick = $urandom_range(0, 9);
         mode_code = (pick < 6) ? MODE_RUN : (pick < 8) ? MODE_WIND :
                     (pick == 8) ? MODE_HOLD : MODE_SPARE;
         write_reg(REG_MODE, {29'($urandom), mode_code});
         write_reg(REG_IGAIN, {7'($urandom), pick_gain()});
         write_reg(REG_PGAIN, {7'($urandom), pick_gain()});
         case ($urandom_range(0, 3))
            0: write_reg(REG_LIMIT, '0);
            1: write_reg(REG_LIMIT, DATA_ALL);
            2: write_reg(REG_LIMIT, 31'($urandom_range(0, 1000)));
            default: write_reg(REG_LIMIT, 31'($urandom));
         endcase
         case ($urandom_range(0, 3))
            0: write_reg(REG_DECAY, '0);
            1: write_reg(REG_DECAY, DATA_ALL);
            2: write_reg(REG_DECAY, 31'($urandom));
            default: write_reg(REG_DECAY, 31'($urandom_range(0, 100000)));
         endcase
         if ($urandom_range(0, 2) == 0)
            write_reg(REG_DECAY + 3'($urandom_range(1, 3)), 31'($urandom));

         sp_base = $urandom_range(0, 65535) - 32768;
         left = PHASE_TICKS;
         while (left > 0) begin
            burst = $urandom_range(1, 40);
            if (burst > left) burst = left;
            repeat (burst) begin
               sp = ($urandom_range(0, 3) == 0) ? SAMPLE_W'($urandom) : SAMPLE_W'(sp_base);
               if ($urandom_range(0, 2) == 0) begin
                  ms_walk = $urandom_range(0, 65535) - 32768;
               end else begin
                  ms_walk = ms_walk + int'($urandom_range(0, 200)) - 100;
                  if (ms_walk > 32767) ms_walk = 32767;
                  if (ms_walk < -32768) ms_walk = -32768;
               end
               ms = SAMPLE_W'(ms_walk);
               send_tick(sp, ms, 1'b0, '0);
               left--;
            end
            case ($urandom_range(0, 19))
               0: drain();
               1, 2, 3, 4, 5: ;
               default: pause($urandom_range(1, 12));
            endcase
         end
      end

      drain();
      repeat (4) @(negedge clock);
      if (drive_expected.size() != 0) begin
         mismatch_count++;
         $display("%0t: %0d drive beats never arrived", $realtime, drive_expected.size());
      end
      $display("Covered %0d control ticks and %0d register writes;",
               ticks_taken, writes_done);
      $display("%0d drive beats checked, %0d mismatches; ticks by mode: run %0d, wind-down %0d, hold %0d",
               beats_checked, mismatch_count, run_ticks, wind_ticks, hold_ticks);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("%0t: run did not complete in time", $realtime);
      $display("TEST FAILED");
      $finish;
   end

endmodule
